// File: hdl/rke256_pkg.sv
// ----------------------------------------------------------------------------
// rke256_pkg: shared types, constants and functions
// S-box, round constants, word layout and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package rke256_pkg;

  // Schedule geometry
  localparam int unsigned NUM_ROUNDS = 14;
  localparam int unsigned RND_W      = 4;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NUM_WORDS  = 8;
  localparam int unsigned FIELD_W    = 64;

  localparam logic [RND_W-1:0] LAST_RND = RND_W'(NUM_ROUNDS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [RND_W-1:0]  rnd_t;

  // Command from controller to datapath
  typedef struct packed {
    logic load;     // capture a new key as round key 0
    logic advance;  // replace the held round key with the next one
    rnd_t rnd;      // index of the round key now held
  } cmd_t;

  // AES forward S-box
  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Round constant used when stepping from round key r to r+1
  function automatic logic [7:0] rcon(input rnd_t r);
    logic [7:0] c;
    unique case (r)
      4'd0:    c = 8'h01;
      4'd1:    c = 8'h02;
      4'd2:    c = 8'h04;
      4'd3:    c = 8'h08;
      4'd4:    c = 8'h10;
      4'd5:    c = 8'h20;
      4'd6:    c = 8'h40;
      4'd7:    c = 8'h80;
      4'd8:    c = 8'h1b;
      4'd9:    c = 8'h36;
      4'd10:   c = 8'h6c;
      4'd11:   c = 8'hd8;
      4'd12:   c = 8'hab;
      4'd13:   c = 8'h4d;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // S-box applied to each byte of a word
  function automatic word_t sub_word(input word_t w);
    word_t s;
    for (int b = 0; b < 4; b++) begin
      s[8*b +: 8] = SBOX[w[8*b +: 8]];
    end
    return s;
  endfunction

  // Move byte 1 into byte 0
  function automatic word_t rot_word(input word_t w);
    return {w[7:0], w[31:8]};
  endfunction

endpackage

// File: hdl/rke256_key_if.sv
// ----------------------------------------------------------------------------
// rke256_key_if: key input channel
// Valid/ready channel carrying one 256-bit key as four 64-bit fields.
// ----------------------------------------------------------------------------
interface rke256_key_if;
  logic                             valid;
  logic                             ready;
  logic [rke256_pkg::FIELD_W-1:0]   key_bytes_0_7;
  logic [rke256_pkg::FIELD_W-1:0]   key_bytes_8_15;
  logic [rke256_pkg::FIELD_W-1:0]   key_bytes_16_23;
  logic [rke256_pkg::FIELD_W-1:0]   key_bytes_24_31;

  modport source (
    output valid, key_bytes_0_7, key_bytes_8_15, key_bytes_16_23, key_bytes_24_31,
    input  ready
  );

  modport sink (
    input  valid, key_bytes_0_7, key_bytes_8_15, key_bytes_16_23, key_bytes_24_31,
    output ready
  );
endinterface

// File: hdl/rke256_rk_if.sv
// ----------------------------------------------------------------------------
// rke256_rk_if: round key output channel
// Valid/ready channel carrying one 256-bit round key with its index and flag.
// ----------------------------------------------------------------------------
interface rke256_rk_if;
  logic                             valid;
  logic                             ready;
  logic [rke256_pkg::FIELD_W-1:0]   round_key_bytes_0_7;
  logic [rke256_pkg::FIELD_W-1:0]   round_key_bytes_8_15;
  logic [rke256_pkg::FIELD_W-1:0]   round_key_bytes_16_23;
  logic [rke256_pkg::FIELD_W-1:0]   round_key_bytes_24_31;
  logic [rke256_pkg::RND_W-1:0]     round_index;
  logic                             last_round;

  modport source (
    output valid, round_key_bytes_0_7, round_key_bytes_8_15,
           round_key_bytes_16_23, round_key_bytes_24_31, round_index, last_round,
    input  ready
  );

  modport sink (
    input  valid, round_key_bytes_0_7, round_key_bytes_8_15,
           round_key_bytes_16_23, round_key_bytes_24_31, round_index, last_round,
    output ready
  );
endinterface

// File: hdl/rijndael256_key_expansion_core.sv
// ----------------------------------------------------------------------------
// rijndael256_key_expansion_core: Rijndael 256/256 key schedule
// Expands one 256-bit key into 15 round keys, one round key per word.
// ----------------------------------------------------------------------------
// Latency: round key 0 is presented the cycle after the key is accepted.
// Throughput: one round key per cycle while the sink is ready;
//   the single round-function step (two S-box layers and XOR chains) sets this.
// A new key is taken in the same cycle as the last round key of the previous one.
// Reset clears the controller only; the round key register holds no reset value.
module rijndael256_key_expansion_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  rke256_key_if.sink  key_i,
  rke256_rk_if.source round_key_o
);

  rke256_pkg::cmd_t cmd;

  rke256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (key_i.valid),
    .in_ready_o  (key_i.ready),
    .out_valid_o (round_key_o.valid),
    .out_ready_i (round_key_o.ready),
    .round_o     (round_key_o.round_index),
    .last_o      (round_key_o.last_round),
    .cmd_o       (cmd)
  );

  rke256_dp u_dp (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .key_0_i (key_i.key_bytes_0_7),
    .key_1_i (key_i.key_bytes_8_15),
    .key_2_i (key_i.key_bytes_16_23),
    .key_3_i (key_i.key_bytes_24_31),
    .rk_0_o  (round_key_o.round_key_bytes_0_7),
    .rk_1_o  (round_key_o.round_key_bytes_8_15),
    .rk_2_o  (round_key_o.round_key_bytes_16_23),
    .rk_3_o  (round_key_o.round_key_bytes_24_31)
  );

  // Accepted key shows up as round key 0 in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_i.valid && key_i.ready) |=>
      (round_key_o.valid && round_key_o.round_index == '0))
    else $error("key accept did not start at round key 0");

  // Round index steps by one after each non-final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (round_key_o.valid && round_key_o.ready && !round_key_o.last_round) |=>
      (round_key_o.valid &&
       round_key_o.round_index == $past(round_key_o.round_index) + 4'd1))
    else $error("round index did not advance by one");

  // Output drops after the final word when no new key arrives
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (round_key_o.valid && round_key_o.ready && round_key_o.last_round &&
     !key_i.valid) |=> !round_key_o.valid)
    else $error("output stayed valid after the final round key");

  // Round index never passes the final round while valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    round_key_o.valid |-> (round_key_o.round_index <= rke256_pkg::LAST_RND))
    else $error("round index out of range");

endmodule

// File: hdl/rke256_ctrl.sv
// ----------------------------------------------------------------------------
// rke256_ctrl: schedule controller
// Tracks the round index, drives the handshakes and commands the datapath.
// ----------------------------------------------------------------------------
module rke256_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rke256_pkg::rnd_t  round_o,
  output logic              last_o,
  output rke256_pkg::cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_q, state_d;
  rke256_pkg::rnd_t rnd_q, rnd_d;
  logic             last;
  logic             in_fire;
  logic             out_fire;

  assign last        = (rnd_q == rke256_pkg::LAST_RND);
  assign out_valid_o = (state_q == ST_RUN);
  assign out_fire    = out_valid_o && out_ready_i;
  // Take a new key when idle or as the final word of the current key leaves
  assign in_ready_o  = (state_q == ST_IDLE) || (out_ready_i && last);
  assign in_fire     = in_valid_i && in_ready_o;

  // Next state and round index
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_RUN;
          rnd_d   = '0;
        end
      end
      ST_RUN: begin
        if (in_fire) begin
          rnd_d = '0;
        end else if (out_fire && last) begin
          state_d = ST_IDLE;
        end else if (out_fire) begin
          rnd_d = rnd_q + rke256_pkg::RND_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  // Drive datapath commands
  assign cmd_o.load    = in_fire;
  assign cmd_o.advance = out_fire && !last;
  assign cmd_o.rnd     = rnd_q;

  assign round_o = rnd_q;
  assign last_o  = last;

endmodule

// File: hdl/rke256_dp.sv
// ----------------------------------------------------------------------------
// rke256_dp: round key datapath
// Holds the current round key and computes the next one in a single step.
// ----------------------------------------------------------------------------
module rke256_dp (
  input  logic                           clk_i,
  input  rke256_pkg::cmd_t               cmd_i,
  input  logic [rke256_pkg::FIELD_W-1:0] key_0_i,
  input  logic [rke256_pkg::FIELD_W-1:0] key_1_i,
  input  logic [rke256_pkg::FIELD_W-1:0] key_2_i,
  input  logic [rke256_pkg::FIELD_W-1:0] key_3_i,
  output logic [rke256_pkg::FIELD_W-1:0] rk_0_o,
  output logic [rke256_pkg::FIELD_W-1:0] rk_1_o,
  output logic [rke256_pkg::FIELD_W-1:0] rk_2_o,
  output logic [rke256_pkg::FIELD_W-1:0] rk_3_o
);

  rke256_pkg::word_t w_q [rke256_pkg::NUM_WORDS];
  rke256_pkg::word_t w_d [rke256_pkg::NUM_WORDS];
  rke256_pkg::word_t nxt [rke256_pkg::NUM_WORDS];

  // Compute the next round key: lower half from w7, upper half from new w3
  always_comb begin
    nxt[0] = w_q[0]
           ^ rke256_pkg::sub_word(rke256_pkg::rot_word(w_q[7]))
           ^ {24'h000000, rke256_pkg::rcon(cmd_i.rnd)};
    for (int i = 1; i < 4; i++) begin
      nxt[i] = w_q[i] ^ nxt[i-1];
    end
    nxt[4] = w_q[4] ^ rke256_pkg::sub_word(nxt[3]);
    for (int i = 5; i < 8; i++) begin
      nxt[i] = w_q[i] ^ nxt[i-1];
    end
  end

  // Load a new key or advance to the next round key
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      w_d[i] = w_q[i];
    end
    if (cmd_i.load) begin
      w_d[0] = key_0_i[31:0];
      w_d[1] = key_0_i[63:32];
      w_d[2] = key_1_i[31:0];
      w_d[3] = key_1_i[63:32];
      w_d[4] = key_2_i[31:0];
      w_d[5] = key_2_i[63:32];
      w_d[6] = key_3_i[31:0];
      w_d[7] = key_3_i[63:32];
    end else if (cmd_i.advance) begin
      for (int i = 0; i < 8; i++) begin
        w_d[i] = nxt[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      w_q[i] <= w_d[i];
    end
  end

  assign rk_0_o = {w_q[1], w_q[0]};
  assign rk_1_o = {w_q[3], w_q[2]};
  assign rk_2_o = {w_q[5], w_q[4]};
  assign rk_3_o = {w_q[7], w_q[6]};

endmodule

// File: dv/tb_rijndael256_key_expansion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rijndael256_key_expansion_core: key schedule testbench
// Sends 256-bit keys, predicts all fifteen round keys of each one, and checks
// every round key word the core returns, field by field and in order. A short
// table of keys comes first, then random keys under varying back-pressure.
// ----------------------------------------------------------------------------
module tb_rijndael256_key_expansion_core;
  import rke256_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 6;
  localparam int NUM_VECTORS  = 12;
  localparam int RANDOM_KEYS  = 116;     // per idling phase
  localparam int NUM_PHASES   = 3;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 400000;

  // Four 64-bit fields of a key or round key; index 0 holds bytes 0..7
  typedef logic [3:0][FIELD_W-1:0] key_t;

  typedef struct packed {
    key_t       bytes;
    rnd_t       index;
    logic       last;
  } round_key_t;

  typedef struct packed {
    key_t       key;
    logic       check_r1;   // round key 1 typed in below
    key_t       r1;
  } key_vector_t;

  // Fields are listed bytes 24..31 first, bytes 0..7 last
  localparam key_vector_t KEY_VECTORS [NUM_VECTORS] = '{
    // all-zero key
    '{key: '0, check_r1: 1'b1,
      r1: {64'hfbfbfbaa_fbfbfbaa, 64'hfbfbfbaa_fbfbfbaa,
           64'h63636362_63636362, 64'h63636362_63636362}},
    // all-ones key
    '{key: '1, check_r1: 1'b1,
      r1: {64'h474747f0_b8b8b80f, 64'h474747f0_b8b8b80f,
           64'h16161617_e9e9e9e8, 64'h16161617_e9e9e9e8}},
    // published 256-bit test key
    '{key: {64'hf4df1409_a310982d, 64'hd708613b_072c351f,
            64'h81777d85_f0ae732b, 64'hbe71ca15_10eb3d60},
      check_r1: 1'b1,
      r1: {64'h9a5b5db7_6e8449be, 64'hcd94d193_1a9cb0a8,
           64'hdefc6720_5f8b1aa5, 64'haf25698e_1154a39b}},
    // ascending bytes
    '{key: {64'h1f1e1d1c_1b1a1918, 64'h17161514_13121110,
            64'h0f0e0d0c_0b0a0908, 64'h07060504_03020100},
      check_r1: 1'b0, r1: '0},
    '{key: {4{64'h55555555_55555555}}, check_r1: 1'b0, r1: '0},
    '{key: {4{64'haaaaaaaa_aaaaaaaa}}, check_r1: 1'b0, r1: '0},
    '{key: {4{64'h00000000_00000001}}, check_r1: 1'b0, r1: '0},
    '{key: {4{64'h80000000_00000000}}, check_r1: 1'b0, r1: '0},
    '{key: {4{64'h00000000_ffffffff}}, check_r1: 1'b0, r1: '0},
    '{key: {4{64'hffffffff_00000000}}, check_r1: 1'b0, r1: '0},
    // only the last word set: exercises rotate and substitute
    '{key: {64'hffffffff_00000000, 64'h0, 64'h0, 64'h0}, check_r1: 1'b0, r1: '0},
    // only word 3 set: exercises the mid-round substitution
    '{key: {64'h0, 64'h0, 64'hffffffff_00000000, 64'h0}, check_r1: 1'b0, r1: '0}
  };

  localparam int SRC_IDLE [NUM_PHASES] = '{32, 56, 0};
  localparam int SNK_IDLE [NUM_PHASES] = '{56, 32, 0};

  logic clk_i;
  logic rst_ni;

  rke256_key_if key_ch ();
  rke256_rk_if  rk_ch ();

  rijndael256_key_expansion_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_ch),
    .round_key_o (rk_ch)
  );

  logic [7:0]  sbox_lut [256];
  round_key_t  pending_round_keys [$];
  int          mismatches;
  int          src_idle_pct;
  int          snk_idle_pct;
  int unsigned cycle_count;

  // Clock
  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // Multiply in GF(2^8) modulo x^8 + x^4 + x^3 + x + 1
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box entry: field inverse (zero maps to zero), then the affine map
  function automatic logic [7:0] sbox_entry(input logic [7:0] x);
    logic [7:0] inv;
    logic [7:0] s;
    inv = 8'h01;
    for (int i = 0; i < 254; i++) inv = gf_mul(inv, x);
    s = inv ^ 8'h63;
    for (int k = 1; k <= 4; k++) s ^= (inv << k) | (inv >> (8 - k));
    return s;
  endfunction

  function automatic word_t sbox_word(input word_t w);
    word_t s;
    for (int b = 0; b < 4; b++) s[8*b +: 8] = sbox_lut[w[8*b +: 8]];
    return s;
  endfunction

  // Expand one key and queue all its round keys; optionally pin round key 1
  function automatic void expand_round_keys(input key_t k, input logic check_r1,
                                            input key_t r1);
    word_t      w [8];
    logic [7:0] rc;
    round_key_t rk;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      w[2*i]   = k[i][31:0];
      w[2*i+1] = k[i][63:32];
    end
    for (int r = 0; r <= NUM_ROUNDS; r++) begin
      if (r > 0) begin
        w[0] ^= sbox_word({w[7][7:0], w[7][31:8]}) ^ {24'h0, rc};
        for (int i = 1; i < 4; i++) w[i] ^= w[i-1];
        w[4] ^= sbox_word(w[3]);
        for (int i = 5; i < 8; i++) w[i] ^= w[i-1];
        rc = gf_mul(rc, 8'h02);
      end
      for (int i = 0; i < 4; i++) rk.bytes[i] = {w[2*i+1], w[2*i]};
      if (r == 1 && check_r1) rk.bytes = r1;
      rk.index = rnd_t'(r);
      rk.last  = (r == NUM_ROUNDS);
      pending_round_keys.push_back(rk);
    end
  endfunction

  // Mostly dense random keys, some sparse, some with one repeated byte
  function automatic key_t random_key();
    key_t k;
    int   style;
    style = $urandom_range(9);
    for (int f = 0; f < 4; f++) begin
      k[f] = {$urandom, $urandom};
      if (style == 0) k[f] &= {$urandom, $urandom} & {$urandom, $urandom};
      else if (style == 1) k[f] = {8{k[0][7:0]}};
    end
    return k;
  endfunction

  task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                 input logic [FIELD_W-1:0] want);
    $display("MISMATCH at %0t: %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Present one key word, idling at random first; predict on acceptance
  task automatic send_key(input key_t k, input logic check_r1, input key_t r1);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      key_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    key_ch.valid           <= 1'b1;
    key_ch.key_bytes_0_7   <= k[0];
    key_ch.key_bytes_8_15  <= k[1];
    key_ch.key_bytes_16_23 <= k[2];
    key_ch.key_bytes_24_31 <= k[3];
    @(posedge clk_i);
    while (!key_ch.ready) @(posedge clk_i);
    expand_round_keys(k, check_r1, r1);
  endtask

  // Drop valid, then hold until every round key is back
  task automatic wait_drained();
    @(negedge clk_i);
    key_ch.valid <= 1'b0;
    wait (pending_round_keys.size() == 0);
  endtask

  // Sink back-pressure
  always @(negedge clk_i) begin
    rk_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Check each accepted round key word against the oldest prediction
  always @(posedge clk_i) begin
    key_t       got;
    round_key_t want;
    if (rst_ni && rk_ch.valid && rk_ch.ready) begin
      got = {rk_ch.round_key_bytes_24_31, rk_ch.round_key_bytes_16_23,
             rk_ch.round_key_bytes_8_15, rk_ch.round_key_bytes_0_7};
      if (pending_round_keys.size() == 0) begin
        report_mismatch("round key with none expected", got[0], '0);
      end else begin
        want = pending_round_keys.pop_front();
        for (int f = 0; f < 4; f++) begin
          if (got[f] !== want.bytes[f])
            report_mismatch($sformatf("round %0d bytes %0d..%0d", want.index, 8*f, 8*f+7),
                            got[f], want.bytes[f]);
        end
        if (rk_ch.round_index !== want.index)
          report_mismatch("round_index", FIELD_W'(rk_ch.round_index), FIELD_W'(want.index));
        if (rk_ch.last_round !== want.last)
          report_mismatch($sformatf("last_round of round %0d", want.index),
                          FIELD_W'(rk_ch.last_round), FIELD_W'(want.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus
  initial begin
    mismatches             = 0;
    cycle_count            = 0;
    src_idle_pct           = SRC_IDLE[0];
    snk_idle_pct           = SNK_IDLE[0];
    rst_ni                 = 1'b0;
    key_ch.valid           = 1'b0;
    key_ch.key_bytes_0_7   = '0;
    key_ch.key_bytes_8_15  = '0;
    key_ch.key_bytes_16_23 = '0;
    key_ch.key_bytes_24_31 = '0;
    rk_ch.ready            = 1'b0;
    for (int i = 0; i < 256; i++) sbox_lut[i] = sbox_entry(8'(i));

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      src_idle_pct = SRC_IDLE[p];
      snk_idle_pct = SNK_IDLE[p];
      // Directed table runs under the first idling mix
      if (p == 0) begin
        for (int v = 0; v < NUM_VECTORS; v++)
          send_key(KEY_VECTORS[v].key, KEY_VECTORS[v].check_r1, KEY_VECTORS[v].r1);
      end
      for (int n = 0; n < RANDOM_KEYS; n++) send_key(random_key(), 1'b0, '0);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
